// File: sv/mts_pkg.sv
`default_nettype none
package mts_pkg;
    localparam int MaxTimers = 16;
    localparam int SlotW = $clog2(MaxTimers);
    localparam int CountW = $clog2(MaxTimers + 1);
    localparam int IdW = 16;
    localparam int PeriodW = 32;
    localparam int ElapsedW = 33;

    localparam logic [2:0] FUNC_TICK = 3'd0;
    localparam logic [2:0] FUNC_START_ONE = 3'd1;
    localparam logic [2:0] FUNC_START_REP = 3'd2;
    localparam logic [2:0] FUNC_CANCEL = 3'd3;
    localparam logic [2:0] FUNC_QUERY = 3'd4;
    localparam logic [2:0] FUNC_CLEAR = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_CHECK,
        ST_DIV,
        ST_WRITE,
        ST_REPORT,
        ST_NEXT,
        ST_SUMMARY,
        ST_CMD,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic slot_clear;
        logic slot_step;
        logic do_add;
        logic div_start;
        logic do_write;
        logic do_cmd;
        logic set_report;
        logic set_summary;
        logic set_resp;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic slot_live;
        logic due;
        logic need_div;
        logic div_done;
        logic slot_last;
    } dp_status_t;
endpackage
`default_nettype wire

// File: sv/mts_div.sv
`default_nettype none
module mts_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [mts_pkg::ElapsedW-1:0]   dividend,
    input  wire logic [mts_pkg::PeriodW-1:0]    divisor,
    output logic                                done,
    output logic [mts_pkg::ElapsedW-1:0]        quotient,
    output logic [mts_pkg::PeriodW-1:0]         remainder
);
    import mts_pkg::*;

    // restoring division, one quotient bit per cycle
    logic [ElapsedW-1:0] quo_reg;
    logic [PeriodW:0]    rem_reg;
    logic [PeriodW-1:0]  dvs_reg;
    logic [5:0]          cnt_reg;
    logic                busy_reg;
    logic [PeriodW:0]    trial;
    logic [PeriodW:0]    shifted;

    assign shifted = {rem_reg[PeriodW-1:0], quo_reg[ElapsedW-1]};
    assign trial = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 6'(ElapsedW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[PeriodW])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[ElapsedW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[ElapsedW-2:0], 1'b0};
            end
        end
    end

    assign done = !busy_reg && !start;
    assign quotient = quo_reg;
    assign remainder = rem_reg[PeriodW-1:0];
endmodule
`default_nettype wire

// File: sv/mts_ctrl.sv
`default_nettype none
module mts_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [2:0]             in_func,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output mts_pkg::dp_cmd_t            cmd,
    input  wire mts_pkg::dp_status_t    status
);
    import mts_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.slot_clear = 1'b1;
                    state_next = (in_func == FUNC_TICK) ? ST_READ : ST_CMD;
                end
            end
            ST_READ:
                state_next = status.slot_live ? ST_ADD : ST_NEXT;
            ST_ADD:
            begin
                cmd.do_add = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!status.due)
                    state_next = ST_NEXT;
                else if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
                else
                    state_next = ST_WRITE;
            end
            ST_DIV:
                if (status.div_done)
                    state_next = ST_WRITE;
            ST_WRITE:
            begin
                cmd.do_write = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    cmd.set_report = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (status.slot_last)
                    state_next = ST_SUMMARY;
                else
                begin
                    cmd.slot_step = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_SUMMARY:
            begin
                if (out_free)
                begin
                    cmd.set_summary = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CMD:
            begin
                cmd.do_cmd = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    cmd.set_resp = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: sv/mts_dp.sv
`default_nettype none
module mts_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [mts_pkg::PeriodW-1:0]    cfg_wdata,
    input  wire logic [2:0]                     func,
    input  wire logic [mts_pkg::PeriodW-1:0]    period,
    input  wire logic [mts_pkg::IdW-1:0]        target_id,
    input  wire logic [mts_pkg::PeriodW-1:0]    delta,
    input  wire mts_pkg::dp_cmd_t               cmd,
    output mts_pkg::dp_status_t                 status,
    output logic                                kind,
    output logic [mts_pkg::IdW-1:0]             timer_ref,
    output logic [7:0]                          fire_count,
    output logic                                ok,
    output logic                                any_fired,
    output logic [4:0]                          live_count,
    output logic                                last
);
    import mts_pkg::*;

    logic [PeriodW-1:0]  min_period_reg;
    logic [MaxTimers-1:0] valid_reg;
    logic [IdW-1:0]      id_mem [MaxTimers];
    logic                rep_mem [MaxTimers];
    logic [PeriodW-1:0]  per_mem [MaxTimers];
    logic [ElapsedW-1:0] ela_mem [MaxTimers];
    logic [IdW-1:0]      next_id_reg;

    logic [2:0]          func_reg;
    logic [PeriodW-1:0]  period_reg;
    logic [IdW-1:0]      target_reg;
    logic [PeriodW-1:0]  delta_reg;
    logic [SlotW-1:0]    slot_reg;
    logic                any_reg;

    logic [IdW-1:0]      cur_id_reg;
    logic                cur_rep_reg;
    logic [PeriodW-1:0]  cur_per_reg;
    logic [ElapsedW-1:0] cur_ela_reg;

    logic                div_done;
    logic [ElapsedW-1:0] quo;
    logic [PeriodW-1:0]  rem;
    logic                need_div;
    logic [7:0]          cnt_sat;

    logic [CountW-1:0]   live_now;
    logic [MaxTimers-1:0] match;
    logic                free_found;
    logic [SlotW-1:0]    free_slot;
    logic                match_found;
    logic [SlotW-1:0]    match_slot;
    logic [PeriodW-1:0]  start_period;
    logic                cmd_ok;
    logic [IdW-1:0]      cmd_ref;
    logic                cmd_ok_reg;
    logic [IdW-1:0]      cmd_ref_reg;

    mts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cur_ela_reg),
        .divisor  (cur_per_reg),
        .done     (div_done),
        .quotient (quo),
        .remainder(rem)
    );

    assign need_div = cur_rep_reg && (cur_per_reg != '0);
    assign cnt_sat = (quo > ElapsedW'(255)) ? 8'd255 : quo[7:0];

    always_comb
    begin
        live_now = '0;
        for (int i = 0; i < MaxTimers; i++)
            live_now = live_now + CountW'(valid_reg[i]);
    end

    always_comb
    begin
        free_found = 1'b0;
        free_slot = '0;
        match_found = 1'b0;
        match_slot = '0;
        for (int i = MaxTimers - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (id_mem[i] == target_reg);
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot = SlotW'(i);
            end
            if (match[i])
            begin
                match_found = 1'b1;
                match_slot = SlotW'(i);
            end
        end
    end

    always_comb
    begin
        start_period = period_reg;
        if (func_reg == FUNC_START_REP && period_reg == '0)
            start_period = (min_period_reg != '0) ? min_period_reg : PeriodW'(1);
    end

    always_comb
    begin
        cmd_ok = 1'b0;
        cmd_ref = '0;
        case (func_reg) inside
            FUNC_START_ONE, FUNC_START_REP:
            begin
                cmd_ok = free_found;
                cmd_ref = free_found ? next_id_reg : '0;
            end
            FUNC_CANCEL, FUNC_QUERY:
            begin
                cmd_ok = match_found;
                cmd_ref = target_reg;
            end
            FUNC_CLEAR:
                cmd_ok = 1'b1;
            default:
                cmd_ok = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg <= PeriodW'(1000);
            valid_reg <= '0;
            next_id_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                min_period_reg <= cfg_wdata;
            if (cmd.do_write && !need_div)
                valid_reg[slot_reg] <= 1'b0;
            if (cmd.do_cmd)
            begin
                case (func_reg) inside
                    FUNC_START_ONE, FUNC_START_REP:
                        if (free_found)
                        begin
                            valid_reg[free_slot] <= 1'b1;
                            next_id_reg <= next_id_reg + IdW'(1);
                        end
                    FUNC_CANCEL:
                        if (match_found)
                            valid_reg[match_slot] <= 1'b0;
                    FUNC_CLEAR:
                        valid_reg <= '0;
                    default:
                        valid_reg <= valid_reg;
                endcase
            end
        end
    end

    // table memories and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg <= func;
            period_reg <= period;
            target_reg <= target_id;
            delta_reg <= delta;
            slot_reg <= '0;
            any_reg <= 1'b0;
        end
        if (cmd.slot_step)
            slot_reg <= slot_reg + SlotW'(1);
        if (cmd.slot_clear || cmd.slot_step)
        begin
            cur_id_reg <= id_mem[cmd.slot_step ? slot_reg + SlotW'(1) : '0];
            cur_rep_reg <= rep_mem[cmd.slot_step ? slot_reg + SlotW'(1) : '0];
            cur_per_reg <= per_mem[cmd.slot_step ? slot_reg + SlotW'(1) : '0];
            cur_ela_reg <= ela_mem[cmd.slot_step ? slot_reg + SlotW'(1) : '0];
        end
        if (cmd.do_add)
        begin
            cur_ela_reg <= cur_ela_reg + ElapsedW'(delta_reg);
            ela_mem[slot_reg] <= cur_ela_reg + ElapsedW'(delta_reg);
        end
        if (cmd.do_write)
        begin
            any_reg <= 1'b1;
            if (need_div)
                ela_mem[slot_reg] <= ElapsedW'(rem);
        end
        if (cmd.do_cmd)
        begin
            cmd_ok_reg <= cmd_ok;
            cmd_ref_reg <= cmd_ref;
            if ((func_reg == FUNC_START_ONE || func_reg == FUNC_START_REP) && free_found)
            begin
                id_mem[free_slot] <= next_id_reg;
                rep_mem[free_slot] <= (func_reg == FUNC_START_REP);
                per_mem[free_slot] <= start_period;
                ela_mem[free_slot] <= '0;
            end
        end
        if (cmd.set_report)
        begin
            kind <= 1'b0;
            timer_ref <= cur_id_reg;
            fire_count <= need_div ? cnt_sat : 8'd1;
            ok <= 1'b0;
            any_fired <= 1'b0;
            live_count <= '0;
            last <= 1'b0;
        end
        if (cmd.set_summary)
        begin
            kind <= 1'b1;
            timer_ref <= '0;
            fire_count <= '0;
            ok <= 1'b1;
            any_fired <= any_reg;
            live_count <= 5'(live_now);
            last <= 1'b1;
        end
        if (cmd.set_resp)
        begin
            kind <= 1'b1;
            timer_ref <= cmd_ref_reg;
            fire_count <= '0;
            ok <= cmd_ok_reg;
            any_fired <= 1'b0;
            live_count <= 5'(live_now);
            last <= 1'b1;
        end
    end

    assign status.slot_live = valid_reg[slot_reg];
    assign status.due = cur_ela_reg >= ElapsedW'(cur_per_reg);
    assign status.need_div = need_div;
    assign status.div_done = div_done;
    assign status.slot_last = (slot_reg == SlotW'(MaxTimers - 1));
endmodule
`default_nettype wire

// File: sv/multi_timer_scheduler.sv
`default_nettype none
// Table of 16 one-shot and repeating timers driven by commands. Commands
// other than a tick pass through a command state and a response state,
// wait out any output stall, and give one response. A tick walks the slots
// one at a time; for each due repeating timer, the elapsed count passes
// through a bit-serial divider to get the fire count and remainder. A tick
// gives a fire report per due timer, then a summary.
// New input is held off until the last result of the current one is
// registered.
module multi_timer_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  func,
    input  wire logic [31:0] period,
    input  wire logic [15:0] target_id,
    input  wire logic [31:0] delta,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [15:0]      timer_ref,
    output logic [7:0]       fire_count,
    output logic             ok,
    output logic             any_fired,
    output logic [4:0]       live_count,
    output logic             last
);
    import mts_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_func  (func),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cmd      (cmd),
        .status   (status)
    );

    mts_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .func      (func),
        .period    (period),
        .target_id (target_id),
        .delta     (delta),
        .cmd       (cmd),
        .status    (status),
        .kind      (kind),
        .timer_ref (timer_ref),
        .fire_count(fire_count),
        .ok        (ok),
        .any_fired (any_fired),
        .live_count(live_count),
        .last      (last)
    );
endmodule
`default_nettype wire

// File: sim/mts_checker.sv
`timescale 1ns / 100ps
module mts_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  func,
    input  logic [31:0] period,
    input  logic [15:0] target_id,
    input  logic [31:0] delta,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        kind,
    input  logic [15:0] timer_ref,
    input  logic [7:0]  fire_count,
    input  logic        ok,
    input  logic        any_fired,
    input  logic [4:0]  live_count,
    input  logic        last,
    output int          errors,
    output int          pending
);
    import mts_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [15:0] timer_ref;
        logic [7:0]  fire_count;
        logic        ok;
        logic        any_fired;
        logic [4:0]  live_count;
        logic        last;
    } timer_result_t;

    timer_result_t due_results[$];

    logic [31:0]         min_rep;
    logic                live   [MaxTimers];
    logic [IdW-1:0]      ids    [MaxTimers];
    logic                rep    [MaxTimers];
    logic [PeriodW-1:0]  per    [MaxTimers];
    logic [ElapsedW-1:0] elapsed[MaxTimers];
    logic [IdW-1:0]      id_next;

    assign pending = due_results.size();

    function automatic logic [4:0] live_total();
        logic [4:0] n;
        n = 0;
        for (int i = 0; i < MaxTimers; i++)
            n += live[i];
        return n;
    endfunction

    function automatic timer_result_t reply(logic [15:0] r, logic k, logic [4:0] lc);
        timer_result_t t;
        t = '0;
        t.kind = 1'b1;
        t.timer_ref = r;
        t.ok = k;
        t.live_count = lc;
        t.last = 1'b1;
        return t;
    endfunction

    task automatic start_timer(logic [31:0] p, logic is_rep);
        int slot;
        slot = -1;
        for (int i = 0; i < MaxTimers; i++)
            if (!live[i] && slot < 0)
                slot = i;
        if (slot < 0)
        begin
            due_results = {due_results, reply(16'd0, 1'b0, live_total())};
        end
        else
        begin
            live[slot] = 1'b1;
            ids[slot] = id_next;
            rep[slot] = is_rep;
            per[slot] = p;
            elapsed[slot] = '0;
            due_results = {due_results, reply(id_next, 1'b1, live_total())};
            id_next++;
        end
    endtask

    task automatic advance_table(logic [2:0] f, logic [31:0] p, logic [15:0] tid,
                                 logic [31:0] d);
        logic          any;
        logic          hit;
        logic [32:0]   cnt;
        timer_result_t t;
        any = 1'b0;
        hit = 1'b0;
        case (f)
            FUNC_TICK:
            begin
                for (int i = 0; i < MaxTimers; i++)
                begin
                    if (live[i])
                    begin
                        elapsed[i] += d;
                        if (elapsed[i] >= {1'b0, per[i]})
                        begin
                            any = 1'b1;
                            if (rep[i] && per[i] != 0)
                            begin
                                cnt = elapsed[i] / per[i];
                                elapsed[i] = elapsed[i] % per[i];
                            end
                            else
                            begin
                                cnt = 1;
                                live[i] = 1'b0;
                            end
                            t = '0;
                            t.timer_ref = ids[i];
                            t.fire_count = (cnt > 255) ? 8'd255 : cnt[7:0];
                            due_results = {due_results, t};
                        end
                    end
                end
                t = reply(16'd0, 1'b1, live_total());
                t.any_fired = any;
                due_results = {due_results, t};
            end
            FUNC_START_ONE: start_timer(p, 1'b0);
            FUNC_START_REP: start_timer(p != 0 ? p : (min_rep != 0 ? min_rep : 32'd1), 1'b1);
            FUNC_CANCEL:
            begin
                for (int i = 0; i < MaxTimers; i++)
                    if (!hit && live[i] && ids[i] == tid)
                    begin
                        live[i] = 1'b0;
                        hit = 1'b1;
                    end
                due_results = {due_results, reply(tid, hit, live_total())};
            end
            FUNC_QUERY:
            begin
                for (int i = 0; i < MaxTimers; i++)
                    if (live[i] && ids[i] == tid)
                        hit = 1'b1;
                due_results = {due_results, reply(tid, hit, live_total())};
            end
            FUNC_CLEAR:
            begin
                for (int i = 0; i < MaxTimers; i++)
                    live[i] = 1'b0;
                due_results = {due_results, reply(16'd0, 1'b1, 5'd0)};
            end
            default: due_results = {due_results, reply(16'd0, 1'b0, live_total())};
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t got;
        timer_result_t want;
        if (!rst_n)
        begin
            errors <= 0;
            min_rep = 32'd1000;
            id_next = '0;
            for (int i = 0; i < MaxTimers; i++)
            begin
                live[i] = 1'b0;
                ids[i] = '0;
                rep[i] = 1'b0;
                per[i] = '0;
                elapsed[i] = '0;
            end
            due_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {kind, timer_ref, fire_count, ok, any_fired, live_count, last};
                if (due_results.size() == 0)
                begin
                    $error("unexpected result %p", got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got != want)
                    begin
                        errors <= errors + 1;
                        if (got.kind != want.kind)
                            $error("kind exp %0d got %0d", want.kind, got.kind);
                        if (got.timer_ref != want.timer_ref)
                            $error("timer_ref exp %0d got %0d", want.timer_ref, got.timer_ref);
                        if (got.fire_count != want.fire_count)
                            $error("fire_count exp %0d got %0d", want.fire_count,
                                   got.fire_count);
                        if (got.ok != want.ok)
                            $error("ok exp %0d got %0d", want.ok, got.ok);
                        if (got.any_fired != want.any_fired)
                            $error("any_fired exp %0d got %0d", want.any_fired, got.any_fired);
                        if (got.live_count != want.live_count)
                            $error("live_count exp %0d got %0d", want.live_count,
                                   got.live_count);
                        if (got.last != want.last)
                            $error("last exp %0d got %0d", want.last, got.last);
                    end
                end
            end
            if (cfg_we)
                min_rep = cfg_wdata;
            if (in_valid && !in_stall)
                advance_table(func, period, target_id, delta);
        end
    end
endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
module tb;
    import mts_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  func = '0;
    logic [31:0] period = '0;
    logic [15:0] target_id = '0;
    logic [31:0] delta = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [15:0] timer_ref;
    logic [7:0]  fire_count;
    logic        ok;
    logic        any_fired;
    logic [4:0]  live_count;
    logic        last;
    int          errors;
    int          pending;
    int          quiet_cycles = 0;
    bit          hold_off = 1'b0;
    logic [15:0] recent_id = '0;

    always #5 clk = ~clk;

    multi_timer_scheduler uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .func(func), .period(period),
        .target_id(target_id), .delta(delta), .out_valid(out_valid),
        .out_stall(out_stall), .kind(kind), .timer_ref(timer_ref),
        .fire_count(fire_count), .ok(ok), .any_fired(any_fired),
        .live_count(live_count), .last(last)
    );

    mts_checker chk (.*);

    // watchdog: no transaction on either side for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("[multi_timer_scheduler] ERROR");
            $finish;
        end
    end

    // track the latest nonzero id in an ok response so cancels and queries tend to hit live timers
    always @(posedge clk)
        if (out_valid && !out_stall && kind && ok && last && timer_ref != 0)
            recent_id <= timer_ref;

    // receiver: random stall per transaction, plus one long hold-off on demand
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send(logic [2:0] f, logic [31:0] p, logic [15:0] t, logic [31:0] d,
                        bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 13) : 0;
        if (w > 0)
        begin
            in_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        period <= p;
        target_id <= t;
        delta <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_min(logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    initial
    begin
        logic [2:0]  f;
        logic [15:0] t;
        logic [31:0] d;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every command, extremes, zero periods, full table
        send(FUNC_QUERY, '0, 16'hFFFF, '0, 0);
        send(FUNC_START_ONE, 32'd0, '0, '0, 0);
        send(FUNC_START_REP, 32'd0, '0, '0, 0);
        send(FUNC_START_REP, 32'd3, '0, '0, 0);
        send(FUNC_START_ONE, 32'hFFFF_FFFF, '0, '0, 0);
        send(FUNC_TICK, '0, '0, 32'd0, 0);
        send(FUNC_TICK, '0, '0, 32'hFFFF_FFFF, 0);
        send(FUNC_QUERY, '0, 16'd2, '0, 0);
        send(FUNC_CANCEL, '0, 16'd2, '0, 0);
        send(FUNC_CANCEL, '0, 16'd2, '0, 0);
        send(3'd6, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send(3'd7, '0, '0, '0, 0);
        for (int i = 0; i < 17; i++)
            send(FUNC_START_REP, 32'd1, '0, '0, 1);
        send(FUNC_TICK, '0, '0, 32'd1000, 0);
        send(FUNC_CLEAR, '0, '0, '0, 0);
        drain();
        write_min(32'd0);
        send(FUNC_START_REP, 32'd0, '0, '0, 0);
        send(FUNC_TICK, '0, '0, 32'd7, 0);
        drain();
        write_min(32'hFFFF_FFFF);
        send(FUNC_START_REP, 32'd0, '0, '0, 0);
        send(FUNC_TICK, '0, '0, 32'hFFFF_FFFF, 0);
        send(FUNC_TICK, '0, '0, 32'hFFFF_FFFF, 0);
        send(FUNC_CLEAR, '0, '0, '0, 0);
        drain();

        // random phases, each with its own repeat minimum
        for (int phase = 0; phase < 5; phase++)
        begin
            write_min(phase == 0 ? 32'd1 : $urandom_range(1, 500));
            if (phase == 2)
                hold_off = 1'b1;
            for (int n = 0; n < 82; n++)
            begin
                case ($urandom_range(0, 9)) inside
                    0, 1, 2: f = FUNC_TICK;
                    3: f = FUNC_START_ONE;
                    4, 5: f = FUNC_START_REP;
                    6: f = FUNC_CANCEL;
                    7: f = FUNC_QUERY;
                    8: f = ($urandom_range(0, 3) == 0) ? FUNC_CLEAR : FUNC_START_REP;
                    default: f = 3'($urandom_range(0, 7));
                endcase
                t = $urandom_range(0, 1) ? 16'(recent_id - $urandom_range(0, 4))
                                         : 16'($urandom);
                case ($urandom_range(0, 4))
                    0: d = $urandom;
                    1: d = 32'd0;
                    default: d = $urandom_range(0, 600);
                endcase
                send(f, pick_period(), t, d, (phase != 1));
            end
            drain();
        end

        if (errors == 0)
            $display("[multi_timer_scheduler] OK");
        else
            $display("[multi_timer_scheduler] ERROR");
        $finish;
    end
endmodule

// File: filelist.f
sv/mts_pkg.sv
sv/mts_div.sv
sv/mts_ctrl.sv
sv/mts_dp.sv
sv/multi_timer_scheduler.sv
sim/mts_checker.sv
sim/tb.sv
